// ===== hdl/thd_pkg.sv =====
// ----------------------------------------------------------------------------
// thd_pkg
// Shared constants, types and codes of the harmonic distortion engine.
// ----------------------------------------------------------------------------
package thd_pkg;

    localparam int MAG_WIDTH_DEF     = 24;
    localparam int MAG_WIDTH_MAX     = 31;
    localparam int MAX_HARMONICS_DEF = 64;

    // Frames that may wait between the accumulator and the root/divide unit.
    localparam int QUEUE_DEPTH = 2;

    localparam int SUM_W      = 64;
    localparam int ROOT_W     = SUM_W / 2;
    localparam int THD_W      = 32;
    localparam int THD_SCALE  = 25600;
    localparam int SCALE_W    = 15;
    localparam int PROD_W     = ROOT_W + SCALE_W;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int DIV_STEPS  = PROD_W;
    localparam int STEP_W     = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FEW       = 2'd1,
        STATUS_ZERO_FUND = 2'd2
    } thd_status_t;

    // One finished frame as handed from the accumulator to the back end.
    typedef struct packed {
        logic [MAG_WIDTH_MAX-1:0] fund;
        logic [SUM_W-1:0]         sum;
        logic                     clipped;
        logic                     few;
    } frame_rec_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQRT,
        BK_SCALE,
        BK_DIV,
        BK_HOLD
    } back_state_t;

endpackage

// ===== hdl/thd_ratio_engine.sv =====
// Streams frames of harmonic magnitudes and returns total harmonic distortion
// in units of 1/256 percent. The front end takes one magnitude per clock cycle
// while s_tready is high, and squares and accumulates it in a two-stage
// pipeline; a two-entry queue holds finished frames. For a normal frame the
// back end loads the record, runs the bit-serial square root, scales, runs the
// bit-serial divide and loads the result register; a frame that is too short
// or has a zero fundamental is loaded and goes straight to the result
// register. The result register is loaded only once the output can take it.
// Input is held off only while the queue holds, or is about to receive, two
// finished frames.

// ----------------------------------------------------------------------------
// thd_ratio_engine
// Top level: accumulator front end, frame queue and root/divide back end.
// ----------------------------------------------------------------------------
module thd_ratio_engine
    import thd_pkg::*;
#(
    parameter int MAG_WIDTH     = MAG_WIDTH_DEF,
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
    localparam int IN_TDATA_W   = ((MAG_WIDTH + 7) / 8) * 8
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // magnitude
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [THD_W-1:0]      m_tdata,   // thd_value
    output logic [2:0]            m_tuser    // status[1:0], saturated
);

    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1);

    logic             q_push;
    frame_rec_t       q_push_rec;
    logic             q_pop;
    frame_rec_t       q_head_rec;
    logic             q_not_empty;
    logic [LVL_W-1:0] q_level;

    thd_front #(
        .MAG_WIDTH     (MAG_WIDTH),
        .MAX_HARMONICS (MAX_HARMONICS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_level  (q_level),
        .q_push   (q_push),
        .q_rec    (q_push_rec)
    );

    thd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_rec  (q_push_rec),
        .pop       (q_pop),
        .head_rec  (q_head_rec),
        .not_empty (q_not_empty),
        .level     (q_level)
    );

    thd_back #(
        .MAG_WIDTH (MAG_WIDTH)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_not_empty),
        .q_rec    (q_head_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// ===== hdl/thd_front.sv =====
// ----------------------------------------------------------------------------
// thd_front
// Accepts harmonic magnitudes, squares them and keeps the frame's sum.
// ----------------------------------------------------------------------------
module thd_front
    import thd_pkg::*;
#(
    parameter int MAG_WIDTH     = MAG_WIDTH_DEF,
    parameter int MAX_HARMONICS = MAX_HARMONICS_DEF,
    localparam int IN_TDATA_W   = ((MAG_WIDTH + 7) / 8) * 8,
    localparam int LVL_W        = $clog2(QUEUE_DEPTH + 1)
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_TDATA_W-1:0] s_tdata,   // magnitude
    input  logic                  s_tlast,
    input  logic [LVL_W-1:0]      q_level,
    output logic                  q_push,
    output frame_rec_t            q_rec
);

    localparam int CNT_W = $clog2(MAX_HARMONICS + 1);
    localparam int SQ_W  = 2 * MAG_WIDTH;

    logic                 accept;
    logic [MAG_WIDTH-1:0] mag;
    logic                 acc_en;

    logic                 mid_frame_reg, mid_frame_next;
    logic [CNT_W-1:0]     item_cnt_reg, item_cnt_next;

    logic                 s1_valid_reg;
    logic                 s1_first_reg;
    logic                 s1_last_reg;
    logic                 s1_acc_reg;
    logic                 s1_few_reg;
    logic [MAG_WIDTH-1:0] s1_mag_reg;
    logic [SQ_W-1:0]      s1_sq_reg;

    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [MAG_WIDTH-1:0] fund_reg, fund_next;
    logic                 clipped_reg, clipped_next;
    logic [SUM_W:0]       sum_add;

    // A last item may enter only if its frame record is sure to find a slot.
    assign s_tready = ({1'b0, q_level} + (LVL_W + 1)'(s1_valid_reg && s1_last_reg))
                      < (LVL_W + 1)'(QUEUE_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign mag      = s_tdata[MAG_WIDTH-1:0];
    assign acc_en   = mid_frame_reg && (item_cnt_reg < CNT_W'(MAX_HARMONICS));

    always_comb
    begin
        mid_frame_next = mid_frame_reg;
        item_cnt_next  = item_cnt_reg;
        if (accept)
        begin
            if (!mid_frame_reg)
            begin
                item_cnt_next = CNT_W'(1);
            end
            else if (acc_en)
            begin
                item_cnt_next = item_cnt_reg + CNT_W'(1);
            end
            mid_frame_next = !s_tlast;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_frame_reg <= 1'b0;
            item_cnt_reg  <= '0;
            s1_valid_reg  <= 1'b0;
        end
        else
        begin
            mid_frame_reg <= mid_frame_next;
            item_cnt_reg  <= item_cnt_next;
            s1_valid_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_first_reg <= !mid_frame_reg;
            s1_last_reg  <= s_tlast;
            s1_acc_reg   <= acc_en;
            s1_few_reg   <= !mid_frame_reg && s_tlast;
            s1_mag_reg   <= mag;
            s1_sq_reg    <= SQ_W'(mag) * SQ_W'(mag);
        end
    end

    assign sum_add = {1'b0, sum_reg} + (SUM_W + 1)'(s1_sq_reg);

    // Harmonics past the limit take neither branch and leave the sum alone.
    always_comb
    begin
        sum_next     = sum_reg;
        fund_next    = fund_reg;
        clipped_next = clipped_reg;
        if (s1_valid_reg)
        begin
            if (s1_first_reg)
            begin
                fund_next    = s1_mag_reg;
                sum_next     = '0;
                clipped_next = 1'b0;
            end
            else if (s1_acc_reg)
            begin
                if (sum_add[SUM_W])
                begin
                    sum_next     = '1;
                    clipped_next = 1'b1;
                end
                else
                begin
                    sum_next = sum_add[SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            fund_reg    <= '0;
            clipped_reg <= 1'b0;
        end
        else
        begin
            sum_reg     <= sum_next;
            fund_reg    <= fund_next;
            clipped_reg <= clipped_next;
        end
    end

    assign q_push       = s1_valid_reg && s1_last_reg;
    assign q_rec.fund    = MAG_WIDTH_MAX'(fund_next);
    assign q_rec.sum     = sum_next;
    assign q_rec.clipped = clipped_next;
    assign q_rec.few     = s1_few_reg;

endmodule

// ===== hdl/thd_queue.sv =====
// ----------------------------------------------------------------------------
// thd_queue
// Short queue of finished frame records between the accumulator and back end.
// ----------------------------------------------------------------------------
module thd_queue
    import thd_pkg::*;
#(
    localparam int LVL_W = $clog2(QUEUE_DEPTH + 1),
    localparam int PTR_W = $clog2(QUEUE_DEPTH)
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  frame_rec_t       push_rec,
    input  logic             pop,
    output frame_rec_t       head_rec,
    output logic             not_empty,
    output logic [LVL_W-1:0] level
);

    frame_rec_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [LVL_W-1:0] level_reg, level_next;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                : rd_ptr_reg + PTR_W'(1);
        end
        unique case ({push, pop})
            2'b10:   level_next = level_reg + LVL_W'(1);
            2'b01:   level_next = level_reg - LVL_W'(1);
            default: level_next = level_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_rec;
        end
    end

    assign head_rec  = slot_reg[rd_ptr_reg];
    assign not_empty = (level_reg != '0);
    assign level     = level_reg;

`ifndef NO_ASSERTIONS
    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (level_reg != LVL_W'(QUEUE_DEPTH)))
        else $error("frame record written into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (level_reg != '0))
        else $error("frame record taken from an empty queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= LVL_W'(QUEUE_DEPTH))
        else $error("queue level beyond its depth");
`endif

endmodule

// ===== hdl/thd_back.sv =====
// ----------------------------------------------------------------------------
// thd_back
// Per-frame square root, scaling and divide, with the result register.
// ----------------------------------------------------------------------------
module thd_back
    import thd_pkg::*;
#(
    parameter int MAG_WIDTH = MAG_WIDTH_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_valid,
    input  frame_rec_t       q_rec,
    output logic             q_pop,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [THD_W-1:0] m_tdata,   // thd_value
    output logic [2:0]       m_tuser    // status[1:0], saturated
);

    back_state_t          state_reg, state_next;
    logic                 load_out;
    logic                 special;
    logic                 fund_zero;

    logic [SUM_W-1:0]     val_reg;
    logic [ROOT_W:0]      rem_sq_reg;
    logic [ROOT_W-1:0]    root_reg;
    logic [STEP_W-1:0]    step_reg;
    logic [PROD_W-1:0]    quo_reg;
    logic [MAG_WIDTH-1:0] rem_dv_reg;
    logic [MAG_WIDTH-1:0] divisor_reg;
    logic                 clipped_reg;
    thd_status_t          status_reg;

    logic [ROOT_W+2:0]    sq_sh, sq_trial, sq_diff;
    logic                 sq_ge;
    logic [MAG_WIDTH:0]   dv_sh, dv_diff;
    logic                 dv_ge;
    logic                 q_ovf;

    logic                 m_tvalid_reg;
    logic [THD_W-1:0]     m_tdata_reg;
    logic [2:0]           m_tuser_reg;

    assign fund_zero = (q_rec.fund[MAG_WIDTH-1:0] == '0);
    assign special   = q_rec.few || fund_zero;

    // One root bit per cycle: bring down two radicand bits, try 4*root+1.
    assign sq_sh    = {rem_sq_reg, val_reg[SUM_W-1 -: 2]};
    assign sq_trial = {1'b0, root_reg, 2'b01};
    assign sq_ge    = (sq_sh >= sq_trial);
    assign sq_diff  = sq_sh - sq_trial;

    // Restoring divide: dividend bits leave the top of quo_reg while the
    // quotient bits enter at the bottom.
    assign dv_sh   = {rem_dv_reg, quo_reg[PROD_W-1]};
    assign dv_ge   = (dv_sh >= {1'b0, divisor_reg});
    assign dv_diff = dv_sh - {1'b0, divisor_reg};

    assign q_ovf = |quo_reg[PROD_W-1:THD_W];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = special ? BK_HOLD : BK_SQRT;
                end
            end
            BK_SQRT:
            begin
                if (step_reg == STEP_W'(SQRT_STEPS - 1))
                begin
                    state_next = BK_SCALE;
                end
            end
            BK_SCALE:
            begin
                state_next = BK_DIV;
            end
            BK_DIV:
            begin
                if (step_reg == STEP_W'(DIV_STEPS - 1))
                begin
                    state_next = BK_HOLD;
                end
            end
            BK_HOLD:
            begin
                if (load_out)
                begin
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb
    begin
        q_pop    = (state_reg == BK_IDLE) && q_valid;
        load_out = (state_reg == BK_HOLD) && (!m_tvalid_reg || m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (load_out)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    val_reg     <= q_rec.sum;
                    divisor_reg <= q_rec.fund[MAG_WIDTH-1:0];
                    clipped_reg <= q_rec.clipped && !special;
                    rem_sq_reg  <= '0;
                    root_reg    <= '0;
                    step_reg    <= '0;
                    quo_reg     <= '0;
                    priority if (q_rec.few)
                    begin
                        status_reg <= STATUS_FEW;
                    end
                    else if (fund_zero)
                    begin
                        status_reg <= STATUS_ZERO_FUND;
                    end
                    else
                    begin
                        status_reg <= STATUS_OK;
                    end
                end
            end
            BK_SQRT:
            begin
                val_reg    <= {val_reg[SUM_W-3:0], 2'b00};
                rem_sq_reg <= sq_ge ? sq_diff[ROOT_W:0] : sq_sh[ROOT_W:0];
                root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
                step_reg   <= step_reg + STEP_W'(1);
            end
            BK_SCALE:
            begin
                quo_reg    <= PROD_W'(root_reg) * PROD_W'(THD_SCALE);
                rem_dv_reg <= '0;
                step_reg   <= '0;
            end
            BK_DIV:
            begin
                quo_reg    <= {quo_reg[PROD_W-2:0], dv_ge};
                rem_dv_reg <= dv_ge ? dv_diff[MAG_WIDTH-1:0] : dv_sh[MAG_WIDTH-1:0];
                step_reg   <= step_reg + STEP_W'(1);
            end
            BK_HOLD:
            begin
                if (load_out)
                begin
                    m_tdata_reg <= q_ovf ? '1 : quo_reg[THD_W-1:0];
                    m_tuser_reg <= {status_reg, clipped_reg || q_ovf};
                end
            end
            default:
            begin
                step_reg <= '0;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

`ifndef NO_ASSERTIONS
    a_special_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tuser[2:1] != STATUS_OK)) |-> ((m_tdata == '0) && !m_tuser[0]))
        else $error("special-case result carries a nonzero value or flag");

    a_pop_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (state_reg != BK_IDLE))
        else $error("frame taken but back end stayed idle");

    a_sqrt_steps: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == BK_SQRT) |-> (step_reg < STEP_W'(SQRT_STEPS)))
        else $error("square root ran past its last step");

    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> m_tvalid)
        else $error("result loaded but not presented");
`endif

endmodule

// ===== tb/thd_ratio_engine_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// thd_ratio_engine_tb
// Streams frames of harmonic magnitudes into the distortion engine with random
// gaps on the input and random stalls on the output. A transaction-level predictor
// of the frame accumulator, root and divide computes each expected result,
// and every output transfer is checked field by field in order.
// ----------------------------------------------------------------------------
module thd_ratio_engine_tb;
    import thd_pkg::*;

    localparam int MAG_W       = MAG_WIDTH_DEF;
    localparam int HARM_LIMIT  = MAX_HARMONICS_DEF;
    localparam int TDATA_W     = ((MAG_W + 7) / 8) * 8;
    localparam int N_ITEMS     = 2000;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 300;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             last;
    } harm_item_t;

    typedef struct packed {
        logic [THD_W-1:0] thd;
        logic             sat;
        thd_status_t      status;
    } thd_result_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [TDATA_W-1:0] s_tdata  = '0;
    logic               s_tlast  = 1'b0;
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [THD_W-1:0]   m_tdata;
    logic [2:0]         m_tuser;

    // Pending magnitudes and the results they are predicted to produce.
    harm_item_t  feed_q[$];
    thd_result_t thd_expected[$];
    harm_item_t  cur_item;
    thd_result_t got_res;
    thd_result_t want_res;
    logic        s_fire = 1'b0;

    // Predictor state of the frame accumulator.
    logic [MAG_W-1:0] frame_fund  = '0;
    logic [63:0]      sq_acc      = '0;
    logic             in_frame    = 1'b0;
    logic             acc_clip    = 1'b0;
    int               harm_count  = 0;
    int               frame_items = 0;

    int s_gap    = 0;
    int s_calm   = 0;
    int rdy_wait = 0;
    int rdy_calm = 0;

    int n_queued   = 0;
    int n_sent     = 0;
    int n_frames   = 0;
    int n_checked  = 0;
    int n_errors   = 0;
    int n_cycles   = 0;
    int n_ok       = 0;
    int n_few      = 0;
    int n_zero     = 0;
    int n_sat      = 0;
    int n_overlong = 0;

    thd_ratio_engine dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly short gaps, a few long ones, and now and then a stretch of none.
    function automatic int pick_gap(inout int calm);
        int r;
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 999);
        if (r < 8)
        begin
            calm = $urandom_range(30, 300);
            return 0;
        end
        if (r < 450)
            return 0;
        if (r < 850)
            return $urandom_range(1, 3);
        if (r < 970)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] floor_root(input logic [63:0] v);
        logic [31:0] root;
        logic [31:0] cand;
        root = '0;
        for (int i = 31; i >= 0; i--)
        begin
            cand = root | (32'd1 << i);
            if ({32'd0, cand} * {32'd0, cand} <= v)
                root = cand;
        end
        return root;
    endfunction

    function automatic logic [MAG_W-1:0] pick_harmonic();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return MAG_MAX;
        return MAG_W'($urandom >> $urandom_range(8, 31));
    endfunction

    // Applies one magnitude to the predicted accumulator and, on the last
    // magnitude of a frame, queues the expected distortion result.
    task automatic thd_predict(input logic [MAG_W-1:0] mag, input logic last);
        logic [64:0] sum_ext;
        logic [63:0] quot;
        thd_result_t res;
        frame_items++;
        if (!in_frame)
        begin
            frame_fund  = mag;
            sq_acc      = '0;
            acc_clip    = 1'b0;
            harm_count  = 1;
            frame_items = 1;
            in_frame    = 1'b1;
        end
        else if (harm_count < HARM_LIMIT)
        begin
            sum_ext = {1'b0, sq_acc} + 65'(64'(mag) * 64'(mag));
            if (sum_ext[64])
            begin
                sq_acc   = '1;
                acc_clip = 1'b1;
            end
            else
                sq_acc = sum_ext[63:0];
            harm_count++;
        end
        if (last)
        begin
            res.thd = '0;
            res.sat = 1'b0;
            if (harm_count < 2)
            begin
                res.status = STATUS_FEW;
                n_few++;
            end
            else if (frame_fund == '0)
            begin
                res.status = STATUS_ZERO_FUND;
                n_zero++;
            end
            else
            begin
                res.status = STATUS_OK;
                n_ok++;
                quot = (64'(floor_root(sq_acc)) * 64'(THD_SCALE)) / 64'(frame_fund);
                res.sat = acc_clip;
                if (quot > 64'hFFFF_FFFF)
                begin
                    res.thd = '1;
                    res.sat = 1'b1;
                end
                else
                    res.thd = quot[31:0];
            end
            if (res.sat)
                n_sat++;
            if (frame_items > HARM_LIMIT)
                n_overlong++;
            n_frames++;
            in_frame = 1'b0;
            thd_expected.push_back(res);
        end
    endtask

    task automatic push_item(input logic [MAG_W-1:0] mag, input logic last);
        harm_item_t it;
        it.mag  = mag;
        it.last = last;
        feed_q.push_back(it);
        n_queued++;
    endtask

    // A frame of len transfers: the fundamental, then harmonics of one value.
    task automatic add_frame(input logic [MAG_W-1:0] fund, input int len,
                             input logic [MAG_W-1:0] harm);
        push_item(fund, len == 1);
        for (int i = 1; i < len; i++)
            push_item(harm, i == len - 1);
    endtask

    // Input side: a new transfer is offered only once the previous one is taken.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (!s_tvalid || s_fire)
            begin
                if (s_gap > 0)
                begin
                    s_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (feed_q.size() != 0)
                begin
                    cur_item = feed_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= TDATA_W'(cur_item.mag);
                    s_tlast  <= cur_item.last;
                    s_gap    = pick_gap(s_calm);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rdy_wait > 0)
            begin
                rdy_wait--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rdy_wait = pick_gap(rdy_calm);
            end
        end
    end

    always @(posedge clk)
    begin
        s_fire <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            thd_predict(s_tdata[MAG_W-1:0], s_tlast);
            n_sent++;
        end
    end

    always @(posedge clk)
    begin
        if (m_tvalid && m_tready)
        begin
            got_res.thd    = m_tdata;
            got_res.sat    = m_tuser[0];
            got_res.status = thd_status_t'(m_tuser[2:1]);
            if (thd_expected.size() == 0)
            begin
                if (n_errors < 10)
                    $display("ERROR: unexpected result thd=%0d sat=%0d status=%0d",
                             got_res.thd, got_res.sat, got_res.status);
                n_errors++;
            end
            else
            begin
                want_res = thd_expected.pop_front();
                n_checked++;
                if (got_res.thd !== want_res.thd || got_res.sat !== want_res.sat
                    || got_res.status !== want_res.status)
                begin
                    if (n_errors < 10)
                        $display("ERROR: result %0d expected thd=%0d sat=%0d status=%0d, got thd=%0d sat=%0d status=%0d",
                                 n_checked, want_res.thd, want_res.sat, want_res.status,
                                 got_res.thd, got_res.sat, got_res.status);
                    n_errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        n_cycles++;
        if (n_cycles >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d results outstanding.",
                     n_cycles, thd_expected.size());
            $display("thd_ratio_engine_tb NOT OK");
            $finish;
        end
    end

    initial
    begin
        int r;
        int len;
        logic [MAG_W-1:0] fund;

        // Directed frames: short frames, zero fundamental, extremes, saturation.
        add_frame(MAG_W'(1000), 1, '0);
        add_frame('0, 1, '0);
        add_frame('0, 3, MAG_W'(7));
        add_frame(MAG_MAX, 2, MAG_MAX);
        add_frame(MAG_W'(1), 2, MAG_MAX);
        add_frame(MAG_W'(1), 3, '0);
        add_frame(MAG_W'(300), 4, MAG_W'(123));
        add_frame(MAG_MAX, 2, '0);
        add_frame(MAG_W'(1), 2, MAG_W'(1));

        // Random frames, mostly short, some running past the harmonic limit.
        while (n_queued < N_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 6)
                len = 1;
            else if (r < 66)
                len = $urandom_range(2, 8);
            else if (r < 92)
                len = $urandom_range(9, 40);
            else
                len = $urandom_range(41, 80);
            r = $urandom_range(0, 99);
            if (r < 5)
                fund = '0;
            else if (r < 12)
                fund = MAG_W'($urandom_range(1, 255));
            else if (r < 16)
                fund = MAG_MAX;
            else
                fund = MAG_W'($urandom);
            push_item(fund, len == 1);
            for (int i = 1; i < len; i++)
                push_item(pick_harmonic(), i == len - 1);
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (n_sent < n_queued || thd_expected.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (thd_expected.size() != 0)
        begin
            $display("ERROR: %0d expected results never arrived", thd_expected.size());
            n_errors++;
        end
        $display("Sent %0d magnitudes in %0d frames (%0d over the harmonic limit).",
                 n_sent, n_frames, n_overlong);
        $display("Checked %0d results: %0d ok, %0d short, %0d zero fundamental, %0d clipped; %0d failures.",
                 n_checked, n_ok, n_few, n_zero, n_sat, n_errors);
        if (n_errors == 0)
            $display("thd_ratio_engine_tb OK");
        else
            $display("thd_ratio_engine_tb NOT OK");
        $finish;
    end

endmodule
